@@ sv/cref_pkg.sv @@
package cref_pkg;

  localparam int DEF_FRAME_WIDTH  = 128;
  localparam int DEF_FRAME_HEIGHT = 128;
  localparam int COORD_W          = 16;
  localparam int COLOR_W          = 16;
  localparam int EXT_W            = 19;
  localparam int SEG_W            = 2;

  localparam logic [COLOR_W-1:0] DIM_MASK = 16'h7BEF;
  localparam logic [SEG_W-1:0]   SEG_LAST = 2'd3;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_HLINE   = 3'd2,
    OP_VLINE   = 3'd3,
    OP_OUTLINE = 3'd4,
    OP_FILL    = 3'd5,
    OP_DIM     = 3'd6,
    OP_CLEAR   = 3'd7
  } cref_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_ADDR,
    ST_WALK,
    ST_DIMW,
    ST_RDWAIT,
    ST_DONE
  } cref_state_t;

  typedef struct packed {
    logic load_cmd;
    logic clip;
    logic set_addr;
    logic next_seg;
    logic step;
    logic mem_we;
    logic dim_wr;
    logic capture_rd;
    logic load_out;
  } cref_cmd_t;

  typedef struct packed {
    logic skip_all;
    logic empty;
    logic last_seg;
    logic last_px;
    logic is_read;
    logic is_dim;
    logic out_free;
  } cref_sts_t;

endpackage

@@ sv/cref_ram.sv @@
module cref_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/cref_ctrl.sv @@
module cref_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cref_pkg::cref_sts_t sts,
  output cref_pkg::cref_cmd_t cmd
);

  cref_pkg::cref_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cref_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      cref_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_nxt    = cref_pkg::ST_CLIP;
        end
      end
      cref_pkg::ST_CLIP: begin
        cmd.clip = 1'b1;
        state_nxt = sts.skip_all ? cref_pkg::ST_DONE : cref_pkg::ST_ADDR;
      end
      cref_pkg::ST_ADDR: begin
        cmd.set_addr = 1'b1;
        priority if (!sts.empty) begin
          state_nxt = cref_pkg::ST_WALK;
        end else if (sts.is_read || sts.last_seg) begin
          state_nxt = cref_pkg::ST_DONE;
        end else begin
          cmd.next_seg = 1'b1;
          state_nxt    = cref_pkg::ST_CLIP;
        end
      end
      cref_pkg::ST_WALK: begin
        priority if (sts.is_read) begin
          state_nxt = cref_pkg::ST_RDWAIT;
        end else if (sts.is_dim) begin
          state_nxt = cref_pkg::ST_DIMW;
        end else begin
          cmd.mem_we = 1'b1;
          priority if (!sts.last_px) begin
            cmd.step = 1'b1;
          end else if (sts.last_seg) begin
            state_nxt = cref_pkg::ST_DONE;
          end else begin
            cmd.next_seg = 1'b1;
            state_nxt    = cref_pkg::ST_CLIP;
          end
        end
      end
      cref_pkg::ST_DIMW: begin
        cmd.mem_we = 1'b1;
        cmd.dim_wr = 1'b1;
        priority if (!sts.last_px) begin
          cmd.step  = 1'b1;
          state_nxt = cref_pkg::ST_WALK;
        end else begin
          state_nxt = cref_pkg::ST_DONE;
        end
      end
      cref_pkg::ST_RDWAIT: begin
        cmd.capture_rd = 1'b1;
        state_nxt      = cref_pkg::ST_DONE;
      end
      cref_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = cref_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cref_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/cref_dp.sv @@
module cref_dp #(
  parameter int FRAME_WIDTH  = cref_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = cref_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [2:0]                         in_req_type,
  input  logic signed [cref_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [cref_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [cref_pkg::COORD_W-1:0] in_width,
  input  logic signed [cref_pkg::COORD_W-1:0] in_height,
  input  logic [cref_pkg::COLOR_W-1:0]       in_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cref_pkg::COLOR_W-1:0]       out_read_color,
  output logic                               out_in_bounds,
  input  cref_pkg::cref_cmd_t                cmd,
  output cref_pkg::cref_sts_t                sts
);

  localparam int XW    = $clog2(FRAME_WIDTH + 1);
  localparam int YW    = $clog2(FRAME_HEIGHT + 1);
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = cref_pkg::EXT_W;
  localparam int CW    = cref_pkg::COORD_W;
  localparam int PW    = cref_pkg::COLOR_W;

  localparam logic signed [EW-1:0] FW_E  = EW'(FRAME_WIDTH);
  localparam logic signed [EW-1:0] FH_E  = EW'(FRAME_HEIGHT);
  localparam logic signed [EW-1:0] ONE_E = EW'(1);
  localparam logic signed [EW-1:0] ZERO_E = EW'(0);
  localparam logic [AW-1:0]        FW_A  = AW'(FRAME_WIDTH);

  cref_pkg::cref_op_t      op_r;
  logic signed [CW-1:0]    x_r, y_r, w_r, h_r;
  logic [PW-1:0]           color_r;
  logic [cref_pkg::SEG_W-1:0] seg_r;

  logic [XW-1:0] x0_r, cw_r, colleft_r;
  logic [YW-1:0] y0_r, ch_r, rowleft_r;
  logic          empty_r;
  logic [AW-1:0] addr_r, rowbase_r;

  logic [PW-1:0] res_color_r;
  logic          res_inb_r;
  logic          out_valid_r;
  logic [PW-1:0] out_color_r;
  logic          out_inb_r;

  logic signed [EW-1:0] xe, ye, we_, he;
  logic signed [EW-1:0] sx, sy, sw, sh;
  logic signed [EW-1:0] lo_x, lo_y, hi_x, hi_y, ex_x, ex_y, span_x, span_y;
  logic                 empty_nxt;
  logic [AW-1:0]        start_addr;
  logic [PW-1:0]        rdata, wdata, dim_data;

  assign xe  = EW'(x_r);
  assign ye  = EW'(y_r);
  assign we_ = EW'(w_r);
  assign he  = EW'(h_r);

  always_comb begin
    sx = xe;
    sy = ye;
    sw = ONE_E;
    sh = ONE_E;
    unique case (op_r)
      cref_pkg::OP_READ, cref_pkg::OP_PIXEL: begin
      end
      cref_pkg::OP_HLINE: begin
        sw = we_;
      end
      cref_pkg::OP_VLINE: begin
        sh = he;
      end
      cref_pkg::OP_OUTLINE: begin
        unique case (seg_r)
          2'd0: begin
            sw = we_;
          end
          2'd1: begin
            sy = ye + he - ONE_E;
            sw = we_;
          end
          2'd2: begin
            sh = he;
          end
          default: begin
            sx = xe + we_ - ONE_E;
            sh = he;
          end
        endcase
      end
      cref_pkg::OP_FILL, cref_pkg::OP_DIM: begin
        sw = we_;
        sh = he;
      end
      cref_pkg::OP_CLEAR: begin
        sx = ZERO_E;
        sy = ZERO_E;
        sw = FW_E;
        sh = FH_E;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lo_x      = (sx < ZERO_E) ? ZERO_E : sx;
    lo_y      = (sy < ZERO_E) ? ZERO_E : sy;
    ex_x      = sx + sw;
    ex_y      = sy + sh;
    hi_x      = (ex_x > FW_E) ? FW_E : ex_x;
    hi_y      = (ex_y > FH_E) ? FH_E : ex_y;
    span_x    = hi_x - lo_x;
    span_y    = hi_y - lo_y;
    empty_nxt = (hi_x <= lo_x) || (hi_y <= lo_y);
  end

  assign start_addr = AW'(AW'(y0_r) * FW_A) + AW'(x0_r);
  assign dim_data   = (rdata >> 1) & cref_pkg::DIM_MASK;
  assign wdata      = cmd.dim_wr ? dim_data : color_r;

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      op_r        <= cref_pkg::cref_op_t'(in_req_type);
      x_r         <= in_pos_x;
      y_r         <= in_pos_y;
      w_r         <= in_width;
      h_r         <= in_height;
      color_r     <= in_color;
      seg_r       <= '0;
      res_color_r <= '0;
      res_inb_r   <= 1'b0;
    end
    if (cmd.next_seg) begin
      seg_r <= seg_r + 1'b1;
    end
    if (cmd.clip) begin
      x0_r    <= lo_x[XW-1:0];
      y0_r    <= lo_y[YW-1:0];
      cw_r    <= span_x[XW-1:0];
      ch_r    <= span_y[YW-1:0];
      empty_r <= empty_nxt;
    end
    if (cmd.set_addr) begin
      addr_r    <= start_addr;
      rowbase_r <= start_addr;
      colleft_r <= cw_r - XW'(1);
      rowleft_r <= ch_r - YW'(1);
    end else if (cmd.step) begin
      if (colleft_r == '0) begin
        rowbase_r <= rowbase_r + FW_A;
        addr_r    <= rowbase_r + FW_A;
        colleft_r <= cw_r - XW'(1);
        rowleft_r <= rowleft_r - YW'(1);
      end else begin
        addr_r    <= addr_r + AW'(1);
        colleft_r <= colleft_r - XW'(1);
      end
    end
    if (cmd.capture_rd) begin
      res_color_r <= rdata;
      res_inb_r   <= 1'b1;
    end
    if (cmd.load_out) begin
      out_color_r <= res_color_r;
      out_inb_r   <= res_inb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  cref_ram #(
    .DATA_W(PW),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (cmd.mem_we),
    .addr (addr_r),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_comb begin
    sts.skip_all = (op_r == cref_pkg::OP_OUTLINE) && ((w_r <= 0) || (h_r <= 0));
    sts.empty    = empty_r;
    sts.last_seg = (op_r != cref_pkg::OP_OUTLINE) || (seg_r == cref_pkg::SEG_LAST);
    sts.last_px  = (colleft_r == '0) && (rowleft_r == '0);
    sts.is_read  = (op_r == cref_pkg::OP_READ);
    sts.is_dim   = (op_r == cref_pkg::OP_DIM);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_read_color = out_color_r;
  assign out_in_bounds  = out_inb_r;

endmodule

@@ sv/clipped_rect_fill_engine.sv @@
// Each segment is clipped, then addressed; paint then writes its pixels in order, and dim
// reads then writes each pixel through the frame RAM port; read captures one pixel. The
// result is loaded into the output register once it is free. Clear paints the whole frame.
// One command at a time; the single frame RAM port sets the pixel rate.
// Reset (rst_n low, synchronous) clears the controller and output valid only;
// frame contents are undefined until cleared or written.
module clipped_rect_fill_engine #(
  parameter int FRAME_WIDTH  = cref_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = cref_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_req_type,
  input  logic signed [cref_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [cref_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [cref_pkg::COORD_W-1:0] in_width,
  input  logic signed [cref_pkg::COORD_W-1:0] in_height,
  input  logic [cref_pkg::COLOR_W-1:0]       in_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cref_pkg::COLOR_W-1:0]       out_read_color,
  output logic                               out_in_bounds
);

  cref_pkg::cref_cmd_t cmd;
  cref_pkg::cref_sts_t sts;

  cref_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  cref_dp #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_width      (in_width),
    .in_height     (in_height),
    .in_color      (in_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_color(out_read_color),
    .out_in_bounds (out_in_bounds),
    .cmd           (cmd),
    .sts           (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second command while busy");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a waiting beat");

  a_color_only_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_bounds |-> out_read_color == '0)
    else $error("nonzero color without in-bounds read");

endmodule
